// File: src/zsn_pkg.sv
package zsn_pkg;
    localparam int SAMPLES_MAX = 64;
    localparam int AW = $clog2(SAMPLES_MAX);
    localparam int CW = AW + 1;
    localparam int SUM_W = 23;
    localparam int SSD_W = 40;
    localparam int NUM_W = 29;
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic load;
        logic clear;
        logic mean_start;
        logic ssd_clear;
        logic ssd_acc;
        logic var_start;
        logic sqrt_start;
        logic z_start;
        logic rd_en;
        logic [AW-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic [CW-1:0] count;
        logic div_done;
        logic sqrt_done;
    } t_sts;
endpackage

// File: src/zsn_divider.sv
module zsn_divider (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [zsn_pkg::SSD_W-1:0] i_num,
    input  logic [zsn_pkg::SSD_W-1:0] i_den,
    output logic o_done,
    output logic [zsn_pkg::SSD_W-1:0] o_quot
);
    import zsn_pkg::*;
    logic [SSD_W-1:0] r_q, r_rem, r_den;
    logic [5:0] r_cnt;
    logic r_busy, r_done;
    logic [SSD_W:0] w_sh;
    assign w_sh = {r_rem, r_q[SSD_W-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= 6'(SSD_W);
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_den}) begin
                    r_rem <= SSD_W'(w_sh - {1'b0, r_den});
                    r_q <= {r_q[SSD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_sh[SSD_W-1:0];
                    r_q <= {r_q[SSD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: src/zsn_datapath.sv
module zsn_datapath (
    input  logic i_clk,
    input  logic i_rst_n,
    input  zsn_pkg::t_cmd i_cmd,
    output zsn_pkg::t_sts o_sts,
    input  logic signed [15:0] i_sample,
    output logic signed [15:0] o_normalized,
    output logic signed [15:0] o_mean_value,
    output logic [15:0] o_spread,
    output logic o_zero_spread,
    output logic o_overflowed
);
    import zsn_pkg::*;
    logic signed [15:0] r_mem [SAMPLES_MAX];
    logic signed [15:0] r_rd;
    logic [CW-1:0] r_count;
    logic signed [SUM_W-1:0] r_sum;
    logic r_drop;
    logic signed [15:0] r_mean;
    logic [SSD_W-1:0] r_ssd;
    logic [15:0] r_sd;
    logic r_sign;
    logic [1:0] r_mode;
    logic signed [17:0] r_d;
    logic [35:0] r_sq;
    logic r_sq_v;

    logic div_start, div_done;
    logic [SSD_W-1:0] div_num, div_den, div_q;
    logic [SSD_W-1:0] n_num;
    logic [SUM_W-1:0] sum_mag;
    logic signed [17:0] w_d;
    logic [17:0] d_mag;
    logic signed [SSD_W-1:0] w_qs;

    localparam logic [1:0] M_MEAN = 2'd0;
    localparam logic [1:0] M_VAR = 2'd1;
    localparam logic [1:0] M_Z = 2'd2;

    assign sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : r_sum;
    assign w_d = 18'(r_rd) - 18'(r_mean);
    assign d_mag = w_d[17] ? 18'(-w_d) : w_d;

    // numerator and divisor are latched by the divider on its start cycle
    always_comb begin
        n_num = '0;
        div_den = SSD_W'(r_count);
        if (i_cmd.mean_start) begin
            n_num = SSD_W'({sum_mag, 1'b0}) + SSD_W'(r_count);
            div_den = SSD_W'({r_count, 1'b0});
        end else if (i_cmd.var_start) begin
            n_num = r_ssd;
        end else if (i_cmd.z_start) begin
            n_num = SSD_W'({d_mag, 13'b0}) + SSD_W'(r_sd);
            div_den = SSD_W'({r_sd, 1'b0});
        end
    end
    assign div_start = i_cmd.mean_start | i_cmd.var_start | i_cmd.z_start;
    assign div_num = n_num;

    zsn_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_q));

    // isqrt: one result bit per cycle over a 32-bit value
    logic [31:0] r_sv, r_res, r_bit;
    logic r_sq_busy, r_sq_done;
    logic [31:0] w_rb;
    assign w_rb = r_res + r_bit;

    assign w_qs = r_sign ? SSD_W'(-$signed(div_q)) : div_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count != CW'(SAMPLES_MAX)) r_mem[r_count[AW-1:0]] <= i_sample;
        if (i_cmd.rd_en) r_rd <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum <= '0;
            r_drop <= 1'b0;
            r_mode <= M_MEAN;
            r_sq_v <= 1'b0;
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_sum <= '0;
                r_drop <= 1'b0;
            end else if (i_cmd.load) begin
                if (r_count == CW'(SAMPLES_MAX)) r_drop <= 1'b1;
                else begin
                    r_count <= r_count + 1'b1;
                    r_sum <= r_sum + SUM_W'(i_sample);
                end
            end
            if (i_cmd.mean_start) begin
                r_mode <= M_MEAN;
                r_sign <= r_sum[SUM_W-1];
            end
            if (i_cmd.var_start) begin
                r_mode <= M_VAR;
                r_sign <= 1'b0;
            end
            if (i_cmd.z_start) begin
                r_mode <= M_Z;
                r_sign <= w_d[17];
            end
            if (div_done && r_mode == M_MEAN) r_mean <= 16'(w_qs);
            if (div_done && r_mode == M_VAR) r_sv <= (div_q > SSD_W'(32'hFFFF_FFFF)) ?
                32'hFFFF_FFFF : div_q[31:0];
            if (div_done && r_mode == M_Z) begin
                if (w_qs > SSD_W'(32767)) o_normalized <= 16'sd32767;
                else if (w_qs < -SSD_W'(32768)) o_normalized <= -16'sd32768;
                else o_normalized <= 16'(w_qs);
            end
            if (i_cmd.ssd_clear) r_ssd <= '0;
            r_sq_v <= i_cmd.ssd_acc;
            if (i_cmd.ssd_acc) r_sq <= d_mag * d_mag;
            if (r_sq_v) r_ssd <= r_ssd + SSD_W'(r_sq);
            if (i_cmd.sqrt_start) begin
                r_sq_busy <= 1'b1;
                r_res <= '0;
                r_bit <= 32'h4000_0000;
            end else if (r_sq_busy) begin
                if (r_sv >= w_rb) begin
                    r_sv <= r_sv - w_rb;
                    r_res <= (r_res >> 1) + r_bit;
                end else r_res <= r_res >> 1;
                r_bit <= r_bit >> 2;
                if (r_bit == 32'd1) begin
                    r_sq_busy <= 1'b0;
                    r_sq_done <= 1'b1;
                end
            end
            if (r_sq_done) r_sd <= (r_res > 32'hFFFF) ? 16'hFFFF : r_res[15:0];
        end
    end

    assign o_sts.full = (r_count == CW'(SAMPLES_MAX));
    assign o_sts.count = r_count;
    assign o_sts.div_done = div_done;
    assign o_sts.sqrt_done = r_sq_done;
    assign o_mean_value = r_mean;
    assign o_spread = r_sd;
    assign o_zero_spread = (r_sd == 16'd0);
    assign o_overflowed = r_drop;
endmodule

// File: src/zsn_ctrl.sv
module zsn_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_fire,
    input  logic i_in_last,
    input  logic i_out_ready,
    input  zsn_pkg::t_sts i_sts,
    output zsn_pkg::t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic [zsn_pkg::AW-1:0] o_pos,
    output logic o_last
);
    import zsn_pkg::*;
    localparam logic [3:0] S_LOAD = 4'd0, S_MEAN = 4'd1, S_SSD = 4'd2, S_SSDW = 4'd3,
        S_VAR = 4'd4, S_SQRT = 4'd5, S_RD = 4'd6, S_RDW = 4'd7, S_ZDIV = 4'd8,
        S_OUT = 4'd9, S_MEANW = 4'd10, S_VARW = 4'd11, S_SQW = 4'd12;
    logic [3:0] r_st, n_st;
    logic [CW-1:0] r_i, n_i;
    logic [2:0] r_w, n_w;

    assign o_in_ready = (r_st == S_LOAD);
    assign o_out_valid = (r_st == S_OUT);
    assign o_pos = r_i[AW-1:0];
    assign o_last = (r_i + 1'b1 == i_sts.count);

    always_comb begin
        n_st = r_st;
        n_i = r_i;
        n_w = r_w;
        o_cmd = '0;
        o_cmd.rd_addr = r_i[AW-1:0];
        unique case (r_st)
            S_LOAD: begin
                o_cmd.load = i_in_fire;
                if (i_in_fire && i_in_last) n_st = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.mean_start = 1'b1;
                n_st = S_MEANW;
            end
            S_MEANW: if (i_sts.div_done) begin
                o_cmd.ssd_clear = 1'b1;
                n_i = '0;
                n_st = S_SSD;
            end
            S_SSD: begin
                o_cmd.rd_en = 1'b1;
                n_st = S_SSDW;
            end
            S_SSDW: begin
                o_cmd.ssd_acc = 1'b1;
                n_i = r_i + 1'b1;
                if (r_i + 1'b1 == i_sts.count) begin
                    n_st = S_VAR;
                    n_w = 3'd3;
                end else n_st = S_SSD;
            end
            S_VAR: begin
                n_w = r_w - 3'd1;
                if (r_w == 3'd0) begin
                    o_cmd.var_start = 1'b1;
                    n_st = S_VARW;
                end
            end
            S_VARW: if (i_sts.div_done) n_st = S_SQRT;
            S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_st = S_SQW;
            end
            S_SQW: if (i_sts.sqrt_done) begin
                n_i = '0;
                n_w = 3'd1;
                n_st = S_RD;
            end
            S_RD: begin
                n_w = r_w - 3'd1;
                if (r_w == 3'd0) begin
                    o_cmd.rd_en = 1'b1;
                    n_st = S_RDW;
                end
            end
            S_RDW: begin
                o_cmd.z_start = 1'b1;
                n_st = S_ZDIV;
            end
            S_ZDIV: if (i_sts.div_done) n_st = S_OUT;
            S_OUT: if (i_out_ready) begin
                n_i = r_i + 1'b1;
                n_w = 3'd1;
                if (o_last) begin
                    o_cmd.clear = 1'b1;
                    n_st = S_LOAD;
                end else n_st = S_RD;
            end
            default: n_st = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_i <= '0;
            r_w <= '0;
        end else begin
            r_st <= n_st;
            r_i <= n_i;
            r_w <= n_w;
        end
    end
endmodule

// File: src/zscore_normalizer.sv
// Load: one word per cycle while in the load state; a word with tlast closes the set.
// Close: mean division, a deviation pass over the stored samples, variance
// division, bit-serial square root, then one division per result (a single
// shared 40-bit restoring divider serves all three kinds of division).
// Reset (i_rst_n low, synchronous) empties the set and clears the drop flag.
module zscore_normalizer (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // sample
    input  logic s_axis_tlast,         // is_last
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [55:0] m_axis_tdata,  // normalized, position, mean_value, spread, pad
    output logic [1:0] m_axis_tuser,   // zero_spread, overflowed
    output logic m_axis_tlast          // end_of_set
);
    import zsn_pkg::*;
    t_cmd cmd;
    t_sts sts;
    logic in_fire, zero;
    logic [AW-1:0] pos;
    logic signed [15:0] norm, mean;
    logic [15:0] sd;
    logic ovf;

    assign in_fire = s_axis_tvalid & s_axis_tready;

    zsn_ctrl u_ctrl (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_in_last(s_axis_tlast), .i_out_ready(m_axis_tready), .i_sts(sts), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_pos(pos),
        .o_last(m_axis_tlast));

    zsn_datapath u_dp (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_sample(s_axis_tdata), .o_normalized(norm), .o_mean_value(mean),
        .o_spread(sd), .o_zero_spread(zero), .o_overflowed(ovf));

    // zero spread forces the result to zero
    assign m_axis_tdata = {2'b00, sd, mean, pos, (zero ? 16'sd0 : norm)};
    assign m_axis_tuser = {ovf, zero};
endmodule

// File: tb/zscore_normalizer_tb.sv
module zscore_normalizer_tb;
    import zsn_pkg::*;

    localparam int RUN_ITEMS = 330;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic signed [15:0] normalized;
        logic [5:0] position;
        logic signed [15:0] mean_value;
        logic [15:0] spread;
        logic zero_spread;
        logic overflowed;
        logic end_of_set;
    } t_zword;

    typedef struct {
        logic signed [15:0] sample;
        logic is_last;
        bit typed;  // expectation written out below instead of predicted
        t_zword want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata;   // sample
    logic s_axis_tlast;          // is_last
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [55:0] m_axis_tdata;   // normalized, position, mean_value, spread, pad
    logic [1:0] m_axis_tuser;    // zero_spread, overflowed
    logic m_axis_tlast;          // end_of_set

    // Predictor copy of the block's set buffer
    logic signed [15:0] set_store [SAMPLES_MAX];
    int set_count;
    longint set_sum;
    bit set_dropped;

    t_zword pending_words [$];
    int errors;
    int cycles;
    int sent_items;
    int idle_pct;
    int stall_pct;

    zscore_normalizer i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("zscore_normalizer_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Divide rounding to nearest, ties away from zero
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Take one accepted word; on the closing word queue the standardized set
    function automatic void predict_standardized(input logic signed [15:0] smp, input logic lst);
        longint mean;
        longint dev;
        longint z;
        longint unsigned ssd;
        longint unsigned sd;
        t_zword w;
        if (set_count < SAMPLES_MAX) begin
            set_store[set_count] = smp;
            set_count++;
            set_sum += smp;
        end else begin
            set_dropped = 1'b1;
        end
        if (!lst) return;
        if (set_count == 0) begin
            set_sum = 0;
            set_dropped = 1'b0;
            return;
        end
        mean = div_nearest(set_sum, set_count);
        ssd = 0;
        for (int i = 0; i < set_count; i++) begin
            dev = longint'(set_store[i]) - mean;
            ssd += longint'(dev * dev);
        end
        sd = int_sqrt(ssd / set_count);
        if (sd > 65535) sd = 65535;
        for (int i = 0; i < set_count; i++) begin
            z = 0;
            if (sd != 0) begin
                dev = longint'(set_store[i]) - mean;
                z = div_nearest(dev * 4096, longint'(sd));
                if (z > 32767) z = 32767;
                if (z < -32768) z = -32768;
            end
            w.normalized = z[15:0];
            w.position = i[5:0];
            w.mean_value = mean[15:0];
            w.spread = sd[15:0];
            w.zero_spread = (sd == 0);
            w.overflowed = set_dropped;
            w.end_of_set = (i == set_count - 1);
            pending_words.push_back(w);
        end
        set_count = 0;
        set_sum = 0;
        set_dropped = 1'b0;
    endfunction

    // Result side: check each accepted word, then pick the next stall
    always @(posedge i_clk) begin
        t_zword w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                w = pending_words.pop_front();
                if (m_axis_tdata[15:0] !== w.normalized)
                    report_mismatch("normalized", $signed(m_axis_tdata[15:0]), w.normalized);
                if (m_axis_tdata[21:16] !== w.position)
                    report_mismatch("position", m_axis_tdata[21:16], w.position);
                if (m_axis_tdata[37:22] !== w.mean_value)
                    report_mismatch("mean_value", $signed(m_axis_tdata[37:22]), w.mean_value);
                if (m_axis_tdata[53:38] !== w.spread)
                    report_mismatch("spread", m_axis_tdata[53:38], w.spread);
                if (m_axis_tuser[0] !== w.zero_spread)
                    report_mismatch("zero_spread", m_axis_tuser[0], w.zero_spread);
                if (m_axis_tuser[1] !== w.overflowed)
                    report_mismatch("overflowed", m_axis_tuser[1], w.overflowed);
                if (m_axis_tlast !== w.end_of_set)
                    report_mismatch("end_of_set", m_axis_tlast, w.end_of_set);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Drive one word; hold it until accepted, then run the predictor
    task automatic send_word(input logic signed [15:0] smp, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tlast <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_standardized(smp, lst);
        sent_items++;
    endtask

    // Pick idling for the phase the run has reached
    task automatic set_phase();
        case (sent_items * 4 / RUN_ITEMS)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 53; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 53; end
            default: begin idle_pct = 31; stall_pct = 31; end
        endcase
    endtask

    // One random set: len words, last on the final one; beyond 64 they drop
    task automatic send_set(input int len, input int shape);
        logic signed [15:0] base;
        logic signed [15:0] smp;
        int odd_pos;
        base = 16'($urandom);
        odd_pos = $urandom_range(len - 1);
        for (int i = 0; i < len; i++) begin
            case (shape)
                0: smp = 16'($urandom);
                1: smp = base + $signed(16'($urandom_range(15))) - 16'sd8;
                2: smp = (i == odd_pos) ? 16'($urandom) : base;
                default: smp = base;
            endcase
            send_word(smp, i == len - 1);
        end
    endtask

    t_row rows [] = '{
        // single-word sets: mean is the word itself, spread zero
        '{16'sh7fff, 1'b1, 1, '{16'sd0, 6'd0, 16'sh7fff, 16'd0, 1'b1, 1'b0, 1'b1}},
        '{16'sh8000, 1'b1, 1, '{16'sd0, 6'd0, 16'sh8000, 16'd0, 1'b1, 1'b0, 1'b1}},
        '{16'sh0000, 1'b1, 1, '{16'sd0, 6'd0, 16'sh0000, 16'd0, 1'b1, 1'b0, 1'b1}},
        '{16'shffff, 1'b1, 1, '{16'sd0, 6'd0, 16'shffff, 16'd0, 1'b1, 1'b0, 1'b1}},
        // both extremes in one set
        '{16'sh8000, 1'b0, 0, '{default: '0}},
        '{16'sh7fff, 1'b1, 0, '{default: '0}},
        // constant set, zero spread
        '{16'sh0100, 1'b0, 0, '{default: '0}},
        '{16'sh0100, 1'b0, 0, '{default: '0}},
        '{16'sh0100, 1'b1, 0, '{default: '0}},
        // outlier well above the rest of the set
        '{16'sh0000, 1'b0, 0, '{default: '0}},
        '{16'sh0000, 1'b0, 0, '{default: '0}},
        '{16'sh0000, 1'b0, 0, '{default: '0}},
        '{16'sh0000, 1'b0, 0, '{default: '0}},
        '{16'sh0000, 1'b0, 0, '{default: '0}},
        '{16'sh7fff, 1'b1, 0, '{default: '0}},
        // mean tie rounding on two two-word sets
        '{16'sh0001, 1'b0, 0, '{default: '0}},
        '{16'sh0002, 1'b1, 0, '{default: '0}},
        '{16'shfffe, 1'b0, 0, '{default: '0}},
        '{16'shffff, 1'b1, 0, '{default: '0}}
    };

    initial begin
        int len;
        int pick;
        errors = 0;
        cycles = 0;
        sent_items = 0;
        idle_pct = 0;
        stall_pct = 0;
        set_count = 0;
        set_sum = 0;
        set_dropped = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            send_word(rows[r].sample, rows[r].is_last);
            if (rows[r].typed) begin
                void'(pending_words.pop_back());
                pending_words.push_back(rows[r].want);
            end
        end

        // Mostly short sets; now and then a full or overflowing one
        while (sent_items < RUN_ITEMS) begin
            set_phase();
            pick = $urandom_range(9);
            if (pick == 0) len = $urandom_range(65, 68);
            else if (pick == 1) len = 64;
            else len = $urandom_range(1, 10);
            send_set(len, $urandom_range(3));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("zscore_normalizer_tb OK");
        end else begin
            $display("zscore_normalizer_tb NOT OK");
        end
        $finish;
    end
endmodule
